// File: hw/rtl/bce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bce_pkg
// Shared types and constants for the battery charge EMA estimator.
// ----------------------------------------------------------------------------
package bce_pkg;

    // Default geometry of the average
    localparam int SAMPLE_BITS_DEF   = 15;
    localparam int FRACTION_BITS_DEF = 8;

    // Configuration register widths
    localparam int ALPHA_W      = 17;
    localparam int EMPTY_W      = 15;
    localparam int GAIN_W       = 20;
    localparam int DELTA_W      = 14;
    localparam int CFG_DATA_W   = 20;
    localparam int CFG_INDEX_W  = 2;

    // Result field widths
    localparam int FILTERED_W   = 15;
    localparam int CHARGE_W     = 14;
    localparam int LAST_PUB_W   = 15;

    // Shared multiplier: first operand width (unsigned gain plus a sign bit)
    localparam int MX_W         = GAIN_W + 1;

    // Q16 arithmetic
    localparam int Q_BITS       = 16;
    localparam logic [ALPHA_W-1:0] ONE_Q16 = ALPHA_W'(65536);
    localparam int FULL_CHARGE  = 10000;

    // Reset values
    localparam logic [ALPHA_W-1:0]    ALPHA_RST    = ALPHA_W'(6554);
    localparam logic [EMPTY_W-1:0]    EMPTY_RST    = EMPTY_W'(9500);
    localparam logic [GAIN_W-1:0]     GAIN_RST     = GAIN_W'(211406);
    localparam logic [DELTA_W-1:0]    DELTA_RST    = DELTA_W'(100);
    localparam logic [LAST_PUB_W-1:0] LAST_PUB_RST = LAST_PUB_W'(-100);

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EMPTY = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DELTA = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture the input sample
        logic mul_avg;   // alpha times (sample - average)
        logic update;    // fold the product into the average
        logic mul_chg;   // (average - empty) times gain
        logic clamp;     // scale and clamp the charge
        logic finish;    // load the output register, update publish state
    } bce_cmd_t;

endpackage

// File: hw/rtl/bce_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bce_ctrl
// Sequencer: steps one item through the datapath and owns the output valid.
// ----------------------------------------------------------------------------
module bce_ctrl
    import bce_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output bce_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_AVG,
        S_UPDATE,
        S_MUL_CHG,
        S_CLAMP,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL_AVG;
                end
            end
            S_MUL_AVG:
            begin
                cmd.mul_avg = 1'b1;
                state_next  = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_MUL_CHG;
            end
            S_MUL_CHG:
            begin
                cmd.mul_chg = 1'b1;
                state_next  = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the output register can take the item
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hw/rtl/bce_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bce_datapath
// Configuration registers, EMA state, shared multiplier and output register.
// ----------------------------------------------------------------------------
module bce_datapath
    import bce_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  bce_cmd_t               cmd,
    input  logic [SAMPLE_BITS-1:0] sample_mv,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [FILTERED_W-1:0]  filtered_mv,
    output logic [CHARGE_W-1:0]    charge_hundredths,
    output logic                   publish
);

    localparam int AVG_W     = SAMPLE_BITS + FRACTION_BITS;
    localparam int EF_W      = EMPTY_W + FRACTION_BITS;
    localparam int CMP_W     = (AVG_W > EF_W) ? AVG_W : EF_W;
    localparam int PW        = MX_W + AVG_W + 1;
    localparam int SHIFT_CHG = Q_BITS + FRACTION_BITS;
    localparam int CV_W      = PW - SHIFT_CHG;

    // Configuration
    logic [ALPHA_W-1:0] alpha_reg;
    logic [EMPTY_W-1:0] empty_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [DELTA_W-1:0] delta_reg;

    // Item state
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [AVG_W-1:0]       avg_reg;
    logic [AVG_W-1:0]       avg_next;
    logic signed [PW-1:0]   prod_reg;
    logic signed [PW-1:0]   prod_next;
    logic                   above_reg;
    logic [CHARGE_W-1:0]    charge_reg;
    logic [CHARGE_W-1:0]    charge_next;
    logic [LAST_PUB_W-1:0]  last_pub_reg;

    // Output register
    logic [FILTERED_W-1:0]  filtered_reg;
    logic [CHARGE_W-1:0]    charge_out_reg;
    logic                   publish_reg;

    logic [ALPHA_W-1:0]      a_sat;
    logic [AVG_W-1:0]        s_fixed;
    logic [EF_W-1:0]         empty_fixed;
    logic signed [AVG_W:0]   avg_delta;
    logic [CMP_W-1:0]        chg_full;
    logic [AVG_W-1:0]        chg_diff;
    logic                    above;
    logic signed [MX_W-1:0]  op_x;
    logic signed [AVG_W:0]   op_y;
    logic signed [PW-1:0]    upd_step;
    logic [AVG_W:0]          avg_upd;
    logic [CV_W-1:0]         c_val;
    logic [CHARGE_W+1:0]     pub_diff;
    logic [CHARGE_W+1:0]     pub_mag;
    logic                    pub;

    assign a_sat       = (alpha_reg > ONE_Q16) ? ONE_Q16 : alpha_reg;
    assign s_fixed     = AVG_W'(sample_reg) << FRACTION_BITS;
    assign empty_fixed = EF_W'(empty_reg) << FRACTION_BITS;
    assign avg_delta   = $signed({1'b0, s_fixed}) - $signed({1'b0, avg_reg});

    assign above    = CMP_W'(avg_reg) > CMP_W'(empty_fixed);
    assign chg_full = CMP_W'(avg_reg) - CMP_W'(empty_fixed);
    assign chg_diff = chg_full[AVG_W-1:0];

    // One multiplier shared by the average step and the charge scaling
    assign op_x      = cmd.mul_avg ? $signed(MX_W'(a_sat)) : $signed({1'b0, gain_reg});
    assign op_y      = cmd.mul_avg ? avg_delta : $signed({1'b0, chg_diff});
    assign prod_next = op_x * op_y;

    // avg + floor(alpha * (s - avg) / 2^16); result stays between avg and s
    assign upd_step = prod_reg >>> Q_BITS;
    assign avg_upd  = {1'b0, avg_reg} + upd_step[AVG_W:0];
    assign avg_next = (avg_reg == '0) ? s_fixed : avg_upd[AVG_W-1:0];

    assign c_val = prod_reg[PW-1:SHIFT_CHG];

    always_comb
    begin
        if (!above_reg)
        begin
            charge_next = '0;
        end
        else if (c_val > CV_W'(FULL_CHARGE))
        begin
            charge_next = CHARGE_W'(FULL_CHARGE);
        end
        else
        begin
            charge_next = c_val[CHARGE_W-1:0];
        end
    end

    // |charge - last published| against the threshold
    assign pub_diff = {2'b00, charge_reg} - {last_pub_reg[LAST_PUB_W-1], last_pub_reg};
    assign pub_mag  = pub_diff[CHARGE_W+1] ? (~pub_diff + 1'b1) : pub_diff;
    assign pub      = pub_mag > {2'b00, delta_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg    <= ALPHA_RST;
            empty_reg    <= EMPTY_RST;
            gain_reg     <= GAIN_RST;
            delta_reg    <= DELTA_RST;
            avg_reg      <= '0;
            last_pub_reg <= LAST_PUB_RST;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_ALPHA: alpha_reg <= cfg_data[ALPHA_W-1:0];
                    REG_EMPTY: empty_reg <= cfg_data[EMPTY_W-1:0];
                    REG_GAIN:  gain_reg  <= cfg_data[GAIN_W-1:0];
                    REG_DELTA: delta_reg <= cfg_data[DELTA_W-1:0];
                    default:   ;
                endcase
            end
            if (cmd.update)
            begin
                avg_reg <= avg_next;
            end
            if (cmd.finish && pub)
            begin
                last_pub_reg <= {1'b0, charge_reg};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample_mv;
        end
        if (cmd.mul_avg || cmd.mul_chg)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.mul_chg)
        begin
            above_reg <= above;
        end
        if (cmd.clamp)
        begin
            charge_reg <= charge_next;
        end
        if (cmd.finish)
        begin
            filtered_reg   <= FILTERED_W'(avg_reg >> FRACTION_BITS);
            charge_out_reg <= charge_reg;
            publish_reg    <= pub;
        end
    end

    assign filtered_mv       = filtered_reg;
    assign charge_hundredths = charge_out_reg;
    assign publish           = publish_reg;

endmodule

// File: hw/rtl/battery_charge_ema_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_charge_ema_estimator
// Exponential moving average of bus voltage with charge estimate and publish.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, sample_mv) takes one voltage sample per
//   item. Output channel (out_valid/out_ready) returns one result per item:
//   filtered_mv, charge_hundredths and publish.
//   Configuration is written through cfg_wen/cfg_index/cfg_data while idle:
//   index 0 alpha_q16, 1 empty_mv, 2 percent_gain_q16, 3 publish_delta.
//   The controller steps each accepted item through S_MUL_AVG, S_UPDATE,
//   S_MUL_CHG, S_CLAMP and S_FINISH, using one shared multiplier twice
//   (average step, charge scaling), and takes no new item meanwhile.
//   A new item is accepted while a finished result waits in the output
//   register; if the receiver stalls, the following item finishes its work
//   and holds in the last step until the output register frees up.
//   Reset loads the register defaults, clears the average (the first sample
//   seeds it) and sets the last published charge to -1.00 percent.
// ----------------------------------------------------------------------------
module battery_charge_ema_estimator
    import bce_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample_mv,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [FILTERED_W-1:0]  filtered_mv,
    output logic [CHARGE_W-1:0]    charge_hundredths,
    output logic                   publish,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    bce_cmd_t cmd;

    bce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    bce_datapath #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sample_mv         (sample_mv),
        .cfg_wen           (cfg_wen),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .filtered_mv       (filtered_mv),
        .charge_hundredths (charge_hundredths),
        .publish           (publish)
    );

`ifndef SYNTHESIS
    // Busy right after taking an item
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("accepted a second item while the first was in flight");

    // Charge never leaves its clamp range
    a_charge_clamped: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (charge_hundredths <= CHARGE_W'(FULL_CHARGE))
    ) else $error("charge above full scale");

    // A result appears only when an item was in flight
    a_result_has_item: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready)
    ) else $error("result without an item in flight");

    // Controller issues at most one datapath step per cycle
    a_one_step: assert property (
        @(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.mul_avg, cmd.update, cmd.mul_chg, cmd.clamp, cmd.finish})
    ) else $error("overlapping datapath commands");
`endif

endmodule
